/* sv/adjacency_matrix_graph_insert_top_macros.svh */
// assertion macros shared by the graph insert block
`ifndef ADJACENCY_MATRIX_GRAPH_INSERT_TOP_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_INSERT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define AMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/amg_pkg.sv */
package amg_pkg;

    // fixed field widths
    localparam int KEY_W          = 32;
    localparam int STATUS_W       = 3;
    localparam int VCOUNT_W       = 6;
    localparam int ACOUNT_W       = 11;
    localparam int MAX_VERTICES_DEF = 32;
    localparam logic [ACOUNT_W-1:0] ARC_LIMIT = 11'd2047;

    // operation codes
    typedef enum logic {
        OP_VERTEX = 1'b0,
        OP_ARC    = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EXISTS     = 3'd2,
        ST_MISSING    = 3'd3,
        ST_ARC_EXISTS = 3'd4
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ROW_T_RD,
        S_ROW_T_WR,
        S_ROW_H_RD,
        S_ROW_H_WR,
        S_DONE
    } state_t;

    // input item
    typedef struct packed {
        logic              opcode;
        logic signed [KEY_W-1:0] first_key;
        logic signed [KEY_W-1:0] second_key;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VCOUNT_W-1:0] vertex_count;
        logic [ACOUNT_W-1:0] arc_count;
    } out_item_t;

    // key search status back to the controller
    typedef struct packed {
        logic done;
        logic found_t;
        logic found_h;
    } srch_rsp_t;

    // adjacency row memory command
    typedef struct packed {
        logic rd;
        logic set;
        logic clr;
    } adj_cmd_t;

endpackage

/* sv/amg_key_search.sv */
module amg_key_search #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  amg_pkg::in_item_t                     item,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     count,
    input  logic                                  wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]       wr_addr,
    output amg_pkg::srch_rsp_t                    rsp,
    output logic [$clog2(MAX_VERTICES)-1:0]       t_idx,
    output logic [$clog2(MAX_VERTICES)-1:0]       h_idx
);
    import amg_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [KEY_W-1:0] key_mem [MAX_VERTICES];
    logic [KEY_W-1:0] key_q_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             active_reg;
    logic             found_t_reg;
    logic             found_h_reg;
    logic [IDX_W-1:0] t_idx_reg;
    logic [IDX_W-1:0] h_idx_reg;
    logic             rd_en;
    logic             hit_t;
    logic             hit_h;

    // one key read per cycle while entries remain
    assign rd_en = active_reg && (ptr_reg < count);

    // compare the key read last cycle against both search keys
    assign hit_t = cmp_vld_reg && (key_q_reg == KEY_W'(item.first_key));
    assign hit_h = cmp_vld_reg && (key_q_reg == KEY_W'(item.second_key));

    // key memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= KEY_W'(item.first_key);
        end
        if (rd_en) begin
            key_q_reg <= key_mem[ptr_reg[IDX_W-1:0]];
        end
        cmp_idx_reg <= ptr_reg[IDX_W-1:0];
    end

    // scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            ptr_reg     <= '0;
            found_t_reg <= 1'b0;
            found_h_reg <= 1'b0;
        end else if (start) begin
            active_reg  <= 1'b1;
            cmp_vld_reg <= 1'b0;
            ptr_reg     <= '0;
            found_t_reg <= 1'b0;
            found_h_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= rd_en;
            if (rd_en) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (rsp.done) begin
                active_reg <= 1'b0;
            end
            if (hit_t && !found_t_reg) begin
                found_t_reg <= 1'b1;
            end
            if (hit_h && !found_h_reg) begin
                found_h_reg <= 1'b1;
            end
        end
    end

    // matching indexes, first match kept
    always_ff @(posedge aclk) begin
        if (hit_t && !found_t_reg) begin
            t_idx_reg <= cmp_idx_reg;
        end
        if (hit_h && !found_h_reg) begin
            h_idx_reg <= cmp_idx_reg;
        end
    end

    assign rsp.done    = active_reg && !rd_en && !cmp_vld_reg;
    assign rsp.found_t = found_t_reg;
    assign rsp.found_h = found_h_reg;
    assign t_idx       = t_idx_reg;
    assign h_idx       = h_idx_reg;

endmodule

/* sv/amg_adj_rows.sv */
module amg_adj_rows #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                             aclk,
    input  amg_pkg::adj_cmd_t                cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]  addr,
    input  logic [$clog2(MAX_VERTICES)-1:0]  bit_sel,
    output logic                             hit
);
    import amg_pkg::*;

    logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_q_reg;
    logic [MAX_VERTICES-1:0] bit_mask;

    // one-hot mask of the selected column
    assign bit_mask = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << bit_sel;

    // row memory: read, set a bit into the row read last, or clear a row
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            row_q_reg <= row_mem[addr];
        end
        if (cmd.set) begin
            row_mem[addr] <= row_q_reg | bit_mask;
        end else if (cmd.clr) begin
            row_mem[addr] <= '0;
        end
    end

    // arc bit test on the row read last
    assign hit = row_q_reg[bit_sel];

endmodule

/* sv/amg_ctrl.sv */
`include "adjacency_matrix_graph_insert_top_macros.svh"

module amg_ctrl #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  amg_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output amg_pkg::out_item_t                    m_data,
    output amg_pkg::in_item_t                     item,
    output logic [$clog2(MAX_VERTICES+1)-1:0]     count,
    output logic                                  srch_start,
    input  amg_pkg::srch_rsp_t                    srch_rsp,
    input  logic [$clog2(MAX_VERTICES)-1:0]       t_idx,
    input  logic [$clog2(MAX_VERTICES)-1:0]       h_idx,
    output logic                                  key_wr_en,
    output logic [$clog2(MAX_VERTICES)-1:0]       key_wr_addr,
    output amg_pkg::adj_cmd_t                     adj_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]       adj_addr,
    output logic [$clog2(MAX_VERTICES)-1:0]       adj_bit,
    input  logic                                  adj_hit
);
    import amg_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    state_t                state_reg, state_next;
    in_item_t              item_reg;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [ACOUNT_W-1:0]   arcs_reg, arcs_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  mode_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;
    logic                  accept;
    logic                  full;
    logic                  load_out;

    assign accept   = s_valid && s_ready;
    assign full     = (used_reg == CNT_W'(MAX_VERTICES));
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == OP_VERTEX && full) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (srch_rsp.done) begin
                    if (item_reg.opcode == OP_ARC && srch_rsp.found_t && srch_rsp.found_h) begin
                        state_next = S_ROW_T_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW_T_RD: state_next = S_ROW_T_WR;
            S_ROW_T_WR: begin
                if (!adj_hit && mode_reg) begin
                    state_next = S_ROW_H_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ROW_H_RD: state_next = S_ROW_H_WR;
            S_ROW_H_WR: state_next = S_DONE;
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory commands and handshake outputs
    always_comb begin
        s_ready     = (state_reg == S_IDLE);
        srch_start  = 1'b0;
        key_wr_en   = 1'b0;
        key_wr_addr = used_reg[IDX_W-1:0];
        adj_cmd     = '0;
        adj_addr    = t_idx;
        adj_bit     = h_idx;
        unique case (state_reg)
            S_IDLE: begin
                srch_start = accept && !(s_data.opcode == OP_VERTEX && full);
            end
            S_SCAN: begin
                // new vertex: store key and clear its row
                if (srch_rsp.done && item_reg.opcode == OP_VERTEX && !srch_rsp.found_t) begin
                    key_wr_en   = 1'b1;
                    adj_cmd.clr = 1'b1;
                    adj_addr    = used_reg[IDX_W-1:0];
                end
            end
            S_ROW_T_RD: adj_cmd.rd = 1'b1;
            S_ROW_T_WR: adj_cmd.set = !adj_hit;
            S_ROW_H_RD: begin
                adj_cmd.rd = 1'b1;
                adj_addr   = h_idx;
            end
            S_ROW_H_WR: begin
                adj_cmd.set = 1'b1;
                adj_addr    = h_idx;
                adj_bit     = t_idx;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // counts and status
    always_comb begin
        used_next   = used_reg;
        arcs_next   = arcs_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_data.opcode == OP_VERTEX && full) begin
                    status_next = ST_FULL;
                end
            end
            S_SCAN: begin
                if (srch_rsp.done) begin
                    if (item_reg.opcode == OP_VERTEX) begin
                        if (srch_rsp.found_t) begin
                            status_next = ST_EXISTS;
                        end else begin
                            status_next = ST_OK;
                            used_next   = used_reg + CNT_W'(1);
                        end
                    end else if (!(srch_rsp.found_t && srch_rsp.found_h)) begin
                        status_next = ST_MISSING;
                    end
                end
            end
            S_ROW_T_WR: begin
                if (adj_hit) begin
                    status_next = ST_ARC_EXISTS;
                end else begin
                    status_next = ST_OK;
                    if (!mode_reg && arcs_reg != ARC_LIMIT) begin
                        arcs_next = arcs_reg + ACOUNT_W'(1);
                    end
                end
            end
            S_ROW_H_WR: begin
                if (arcs_reg != ARC_LIMIT) begin
                    arcs_next = arcs_reg + ACOUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            arcs_reg    <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            arcs_reg  <= arcs_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            item_reg <= s_data;
        end
        if (load_out) begin
            m_data_reg.status       <= status_reg;
            m_data_reg.vertex_count <= VCOUNT_W'(used_reg);
            m_data_reg.arc_count    <= arcs_reg;
        end
    end

    assign item    = item_reg;
    assign count   = used_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `AMG_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(MAX_VERTICES), "vertex count over limit")
    `AMG_ASSERT_NOW(a_arc_step, arcs_reg != arcs_next, state_reg == S_ROW_T_WR || state_reg == S_ROW_H_WR, "arc count moved outside an arc write")
    `AMG_ASSERT_NOW(a_done_in_scan, srch_rsp.done, state_reg == S_SCAN, "key search finished outside scan")
    `AMG_ASSERT_NEXT(a_result_shown, load_out, m_valid_reg, "result loaded but not shown")

endmodule

/* sv/adjacency_matrix_graph_insert_top.sv */
// Graph builder holding vertex keys and a bit adjacency matrix.
// Input channel s_valid/s_ready/s_data carries one operation per item:
// insert vertex (first_key) or insert arc (first_key tail, second_key head).
// Result channel m_valid/m_ready/m_data returns one item per operation with
// the status code and the vertex and arc counts after that operation.
// cfg_wr_en/cfg_wr_data writes the undirected mode bit; write only when idle.
// Every operation but a vertex rejected by a full table first scans the key
// memory, one key a cycle; an arc whose keys are both found then adds a
// read-modify-write of the tail row and, in undirected mode when that arc is
// new, one of the head row. The next item is taken in the cycle after the
// result is loaded into the output register.
// A column clear on vertex insert is not needed: rows are cleared whole when
// their vertex is added and only bits of existing vertices are ever set.
// Reset (aresetn low, synchronous) empties the graph and clears the mode;
// memory contents are not cleared, no reset sweep takes place.
// If the receiver stalls, the result waits in the output register; one more
// item is accepted and worked, and it holds in its final state until the
// output register frees.
module adjacency_matrix_graph_insert_top #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  amg_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output amg_pkg::out_item_t   m_data
);
    import amg_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    in_item_t         item;
    logic [CNT_W-1:0] count;
    logic             srch_start;
    srch_rsp_t        srch_rsp;
    logic [IDX_W-1:0] t_idx;
    logic [IDX_W-1:0] h_idx;
    logic             key_wr_en;
    logic [IDX_W-1:0] key_wr_addr;
    adj_cmd_t         adj_cmd;
    logic [IDX_W-1:0] adj_addr;
    logic [IDX_W-1:0] adj_bit;
    logic             adj_hit;

    // sequencer, counts and output register
    amg_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .item        (item),
        .count       (count),
        .srch_start  (srch_start),
        .srch_rsp    (srch_rsp),
        .t_idx       (t_idx),
        .h_idx       (h_idx),
        .key_wr_en   (key_wr_en),
        .key_wr_addr (key_wr_addr),
        .adj_cmd     (adj_cmd),
        .adj_addr    (adj_addr),
        .adj_bit     (adj_bit),
        .adj_hit     (adj_hit)
    );

    // key memory and sequential search
    amg_key_search #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_key_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (srch_start),
        .item    (item),
        .count   (count),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .rsp     (srch_rsp),
        .t_idx   (t_idx),
        .h_idx   (h_idx)
    );

    // adjacency row memory
    amg_adj_rows #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_rows (
        .aclk    (aclk),
        .cmd     (adj_cmd),
        .addr    (adj_addr),
        .bit_sel (adj_bit),
        .hit     (adj_hit)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import amg_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;

    // one row of the directed stimulus table
    typedef struct {
        logic      mode;
        in_item_t  op;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // graph shadow kept by the predictor
    logic [KEY_W-1:0] vkey [NV];
    logic [NV-1:0]    adj_row [NV];
    int unsigned      n_vert = 0;
    int unsigned      n_arc = 0;
    logic             undirected = 1'b0;

    out_item_t graph_results [$];
    dir_row_t  dir_rows [$];
    int        mismatches = 0;
    int        burst_left = 0;
    logic [15:0] rx_cycle = '0;
    int        ready_pct = 100;

    adjacency_matrix_graph_insert_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #10 aclk = ~aclk;

    // slot of a stored key, -1 when absent
    function automatic int key_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < n_vert; i++) begin
            if (vkey[i] == key) return i;
        end
        return -1;
    endfunction

    // apply one operation to the shadow graph and give the result item
    function automatic out_item_t graph_apply(in_item_t it);
        int        t;
        int        h;
        status_t   st;
        out_item_t r;
        if (it.opcode == OP_VERTEX) begin
            if (n_vert >= NV) begin
                st = ST_FULL;
            end else if (key_slot(it.first_key) >= 0) begin
                st = ST_EXISTS;
            end else begin
                vkey[n_vert] = it.first_key;
                adj_row[n_vert] = '0;
                for (int i = 0; i < n_vert; i++) adj_row[i][n_vert] = 1'b0;
                n_vert++;
                st = ST_OK;
            end
        end else begin
            t = key_slot(it.first_key);
            h = key_slot(it.second_key);
            if (t < 0 || h < 0) begin
                st = ST_MISSING;
            end else if (adj_row[t][h]) begin
                st = ST_ARC_EXISTS;
            end else begin
                adj_row[t][h] = 1'b1;
                if (undirected) adj_row[h][t] = 1'b1;
                if (n_arc < ARC_LIMIT) n_arc++;
                st = ST_OK;
            end
        end
        r.status = st;
        r.vertex_count = n_vert[VCOUNT_W-1:0];
        r.arc_count = n_arc[ACOUNT_W-1:0];
        return r;
    endfunction

    // key that is stored with the given percentage, else an edge value or random
    function automatic logic [KEY_W-1:0] pick_key(int pct_known);
        int r;
        r = $urandom_range(0, 99);
        if (n_vert > 0 && r < pct_known) return vkey[$urandom_range(0, n_vert - 1)];
        if (r < pct_known + 8) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    task automatic add_row(logic mode, op_t op, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2,
                           bit typed, status_t st, int vc, int ac);
        dir_row_t row;
        row.mode = mode;
        row.op.opcode = op;
        row.op.first_key = k1;
        row.op.second_key = k2;
        row.typed = typed;
        row.want.status = st;
        row.want.vertex_count = vc[VCOUNT_W-1:0];
        row.want.arc_count = ac[ACOUNT_W-1:0];
        dir_rows.push_back(row);
    endtask

    // gap between bursts of items
    task automatic idle_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // offer one item, hold it until taken, then record its expected result
    task automatic send_op(in_item_t it, bit typed, out_item_t want);
        out_item_t pred;
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = graph_apply(it);
        graph_results.push_back(typed ? want : pred);
    endtask

    // drain all results, then write the mode register
    task automatic set_mode(logic mode);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (graph_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        undirected = mode;
    endtask

    // receiver ready pattern, picks a new ready rate whenever the low byte of rx_cycle is zero
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[7:0] == 8'd0) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 75;
                2: ready_pct <= 40;
                default: ready_pct <= 10;
            endcase
        end
        m_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (graph_results.size() == 0) begin
                $display("%0t unexpected result item: expected none, actual %p", $time, m_data);
                mismatches++;
            end else begin
                want = graph_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t status field: expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.vertex_count !== want.vertex_count) begin
                    $display("%0t vertex_count: expected %0d, actual %0d",
                             $time, want.vertex_count, m_data.vertex_count);
                    mismatches++;
                end
                if (m_data.arc_count !== want.arc_count) begin
                    $display("%0t arc_count: expected %0d, actual %0d",
                             $time, want.arc_count, m_data.arc_count);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        in_item_t it;

        // directed table: mode, op, first key, second key, typed, status, vertices, arcs
        add_row(0, OP_ARC,    32'h0000_0001, 32'h0000_0002, 1, ST_MISSING,    0, 0);
        add_row(0, OP_VERTEX, 32'h8000_0000, 32'h0000_0000, 1, ST_OK,         1, 0);
        add_row(0, OP_VERTEX, 32'h7fff_ffff, 32'h7fff_ffff, 1, ST_OK,         2, 0);
        add_row(0, OP_VERTEX, 32'h8000_0000, 32'h1234_5678, 1, ST_EXISTS,     2, 0);
        add_row(0, OP_VERTEX, 32'hffff_ffff, 32'hffff_ffff, 1, ST_OK,         3, 0);
        add_row(0, OP_VERTEX, 32'h0000_0000, 32'h8000_0000, 0, ST_OK,         0, 0);
        add_row(0, OP_ARC,    32'h8000_0000, 32'h7fff_ffff, 0, ST_OK,         0, 0);
        add_row(0, OP_ARC,    32'h8000_0000, 32'h7fff_ffff, 1, ST_ARC_EXISTS, 4, 1);
        add_row(0, OP_ARC,    32'h7fff_ffff, 32'h8000_0000, 0, ST_OK,         0, 0);
        add_row(0, OP_ARC,    32'h8000_0000, 32'h0001_2345, 1, ST_MISSING,    4, 2);
        add_row(0, OP_ARC,    32'h0001_2345, 32'h8000_0000, 1, ST_MISSING,    4, 2);
        add_row(0, OP_ARC,    32'h0001_2345, 32'h0001_2345, 1, ST_MISSING,    4, 2);
        // self loop
        add_row(0, OP_ARC,    32'hffff_ffff, 32'hffff_ffff, 0, ST_OK,         0, 0);
        add_row(0, OP_ARC,    32'hffff_ffff, 32'hffff_ffff, 1, ST_ARC_EXISTS, 4, 3);
        add_row(0, OP_VERTEX, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 0, ST_OK,         0, 0);
        // undirected: mirror bit, self loop counted once, older arcs kept
        add_row(1, OP_ARC,    32'h0000_0000, 32'h5a5a_5a5a, 0, ST_OK,         0, 0);
        add_row(1, OP_ARC,    32'h5a5a_5a5a, 32'h0000_0000, 1, ST_ARC_EXISTS, 5, 4);
        add_row(1, OP_ARC,    32'h0000_0000, 32'h0000_0000, 0, ST_OK,         0, 0);
        add_row(1, OP_ARC,    32'h0000_0000, 32'h0000_0000, 1, ST_ARC_EXISTS, 5, 5);
        add_row(1, OP_ARC,    32'h7fff_ffff, 32'h8000_0000, 1, ST_ARC_EXISTS, 5, 5);
        add_row(1, OP_ARC,    32'h7fff_ffff, 32'hffff_ffff, 0, ST_OK,         0, 0);
        // back to directed: mirror bits stay
        add_row(0, OP_ARC,    32'hffff_ffff, 32'h7fff_ffff, 1, ST_ARC_EXISTS, 5, 6);
        add_row(0, OP_ARC,    32'h5a5a_5a5a, 32'hffff_ffff, 0, ST_OK,         0, 0);
        add_row(0, OP_ARC,    32'hffff_ffff, 32'h5a5a_5a5a, 0, ST_OK,         0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != undirected) set_mode(dir_rows[i].mode);
            idle_gap();
            send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, alternating graph mode
        for (int p = 0; p < 5; p++) begin
            set_mode(p % 2 == 0);
            for (int i = 0; i < 350; i++) begin
                it.opcode = ($urandom_range(0, 99) < ((n_vert < NV) ? 35 : 15))
                            ? OP_VERTEX : OP_ARC;
                it.first_key = pick_key((it.opcode == OP_VERTEX) ? 40 : 85);
                it.second_key = pick_key(85);
                idle_gap();
                send_op(it, 1'b0, '0);
            end
        end

        // drain and let the block settle
        s_valid <= 1'b0;
        @(posedge aclk);
        while (graph_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/amg_pkg.sv
sv/amg_key_search.sv
sv/amg_adj_rows.sv
sv/amg_ctrl.sv
sv/adjacency_matrix_graph_insert_top.sv
tb/sv/testbench.sv
